// ===== hw/rtl/lvm_pkg.sv =====
// Shared constants and helpers for the look-at view matrix pipeline.
package lvm_pkg;

    // Fraction bits of the rotation rows (Q2.30)
    localparam int ROT_FRAC_BITS = 30;

    // Unit length in Q2.30
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

    // Position of the highest set bit plus one; zero for a zero word
    function automatic logic [6:0] bit_len64(input logic [63:0] v);
        logic [6:0] len;
        len = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (v[i])
            begin
                len = 7'(i + 1);
            end
        end
        return len;
    endfunction

endpackage

// ===== hw/rtl/lvm_norm.sv =====
// Pipelined vector normalizer: block scaling, squared length, square root, divide.
module lvm_norm
    import lvm_pkg::*;
#(
    parameter int IN_W   = 33,
    parameter int SIDE_W = 8
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [2:0][IN_W-1:0]   in_c,
    input  logic [SIDE_W-1:0]      in_side,
    output logic                   out_valid,
    output logic [2:0][31:0]       out_u,
    output logic [SIDE_W-1:0]      out_side
);

    localparam int LEN_W = $clog2(IN_W + 1);
    localparam int SQ_N  = 32;
    localparam int DV_N  = ROT_FRAC_BITS + 1;

    // Stage A: magnitudes, signs and common bit length
    logic [2:0][IN_W-1:0] a_mag_next;
    logic [IN_W-1:0]      a_or;
    logic [6:0]           a_len_full;
    logic                 a_valid_reg;
    logic [2:0][IN_W-1:0] a_mag_reg;
    logic [2:0]           a_neg_reg;
    logic [LEN_W-1:0]     a_len_reg;
    logic [SIDE_W-1:0]    a_side_reg;

    always_comb
    begin
        a_or = '0;
        for (int i = 0; i < 3; i++)
        begin
            a_mag_next[i] = in_c[i][IN_W-1] ? (~in_c[i] + 1'b1) : in_c[i];
            a_or          = a_or | a_mag_next[i];
        end
        a_len_full = bit_len64(64'(a_or));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_mag_reg  <= a_mag_next;
            for (int i = 0; i < 3; i++)
            begin
                a_neg_reg[i] <= in_c[i][IN_W-1];
            end
            a_len_reg  <= a_len_full[LEN_W-1:0];
            a_side_reg <= in_side;
        end
    end

    // Stage B: shift so the largest magnitude lands in [2^29, 2^30)
    logic [2:0][29:0]     b_m_next;
    logic [IN_W+29:0]     b_sh;
    logic                 b_valid_reg;
    logic [2:0][29:0]     b_m_reg;
    logic [2:0]           b_neg_reg;
    logic [SIDE_W-1:0]    b_side_reg;

    always_comb
    begin
        b_sh = '0;
        for (int i = 0; i < 3; i++)
        begin
            b_sh        = {a_mag_reg[i], 30'b0} >> a_len_reg;
            b_m_next[i] = b_sh[29:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_m_reg    <= b_m_next;
            b_neg_reg  <= a_neg_reg;
            b_side_reg <= a_side_reg;
        end
    end

    // Stage C: squares
    logic                 c_valid_reg;
    logic [2:0][59:0]     c_sq_reg;
    logic [2:0][29:0]     c_m_reg;
    logic [2:0]           c_neg_reg;
    logic [SIDE_W-1:0]    c_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                c_sq_reg[i] <= 60'(b_m_reg[i]) * 60'(b_m_reg[i]);
            end
            c_m_reg    <= b_m_reg;
            c_neg_reg  <= b_neg_reg;
            c_side_reg <= b_side_reg;
        end
    end

    // Square root pipeline: one root bit per stage, index 0 holds the sum
    logic                 sq_valid_reg [0:SQ_N];
    logic [63:0]          sq_s_reg     [0:SQ_N];
    logic [33:0]          sq_rem_reg   [0:SQ_N];
    logic [31:0]          sq_root_reg  [0:SQ_N];
    logic [2:0][29:0]     sq_m_reg     [0:SQ_N];
    logic [2:0]           sq_neg_reg   [0:SQ_N];
    logic [SIDE_W-1:0]    sq_side_reg  [0:SQ_N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            sq_valid_reg[0] <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_s_reg[0]    <= {2'b0, 62'(c_sq_reg[0]) + 62'(c_sq_reg[1]) + 62'(c_sq_reg[2])};
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_m_reg[0]    <= c_m_reg;
            sq_neg_reg[0]  <= c_neg_reg;
            sq_side_reg[0] <= c_side_reg;
        end
    end

    for (genvar j = 0; j < SQ_N; j++)
    begin : g_sqrt
        logic [35:0] cat;
        logic [35:0] trial_sub;
        logic        ge;
        logic [35:0] diff;

        always_comb
        begin
            cat       = {sq_rem_reg[j], sq_s_reg[j][63:62]};
            trial_sub = 36'({sq_root_reg[j], 2'b01});
            ge        = (cat >= trial_sub);
            diff      = cat - trial_sub;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_valid_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                sq_valid_reg[j+1] <= sq_valid_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_rem_reg[j+1]  <= ge ? diff[33:0] : cat[33:0];
                sq_root_reg[j+1] <= {sq_root_reg[j][30:0], ge};
                sq_s_reg[j+1]    <= {sq_s_reg[j][61:0], 2'b00};
                sq_m_reg[j+1]    <= sq_m_reg[j];
                sq_neg_reg[j+1]  <= sq_neg_reg[j];
                sq_side_reg[j+1] <= sq_side_reg[j];
            end
        end
    end

    // Divide pipeline: index 0 holds the rounded dividend, one quotient bit per stage
    logic                 dv_valid_reg [0:DV_N];
    logic [2:0][61:0]     dv_rem_reg   [0:DV_N];
    logic [2:0][30:0]     dv_q_reg     [0:DV_N];
    logic [31:0]          dv_n_reg     [0:DV_N];
    logic [2:0]           dv_neg_reg   [0:DV_N];
    logic [SIDE_W-1:0]    dv_side_reg  [0:DV_N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_valid_reg[0] <= sq_valid_reg[SQ_N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dv_rem_reg[0][i] <= {2'b0, sq_m_reg[SQ_N][i], 30'b0}
                                    + 62'(sq_root_reg[SQ_N] >> 1);
            end
            dv_q_reg[0]    <= '0;
            dv_n_reg[0]    <= sq_root_reg[SQ_N];
            dv_neg_reg[0]  <= sq_neg_reg[SQ_N];
            dv_side_reg[0] <= sq_side_reg[SQ_N];
        end
    end

    for (genvar t = 0; t < DV_N; t++)
    begin : g_div
        localparam int K = ROT_FRAC_BITS - t;
        logic [61:0]      dvs;
        logic [2:0]       ge;
        logic [2:0][61:0] rem_next;

        always_comb
        begin
            dvs = 62'(dv_n_reg[t]) << K;
            for (int i = 0; i < 3; i++)
            begin
                ge[i]       = (dv_rem_reg[t][i] >= dvs);
                rem_next[i] = ge[i] ? (dv_rem_reg[t][i] - dvs) : dv_rem_reg[t][i];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[t+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_valid_reg[t+1] <= dv_valid_reg[t];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_rem_reg[t+1] <= rem_next;
                for (int i = 0; i < 3; i++)
                begin
                    dv_q_reg[t+1][i] <= {dv_q_reg[t][i][29:0], ge[i]};
                end
                dv_n_reg[t+1]    <= dv_n_reg[t];
                dv_neg_reg[t+1]  <= dv_neg_reg[t];
                dv_side_reg[t+1] <= dv_side_reg[t];
            end
        end
    end

    // Output stage: apply sign, force zero for a zero-length vector
    logic [2:0][31:0] u_next;
    logic             o_valid_reg;
    logic [2:0][31:0] o_u_reg;
    logic [SIDE_W-1:0] o_side_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dv_n_reg[DV_N] == '0)
            begin
                u_next[i] = '0;
            end
            else if (dv_neg_reg[DV_N][i])
            begin
                u_next[i] = -{1'b0, dv_q_reg[DV_N][i]};
            end
            else
            begin
                u_next[i] = {1'b0, dv_q_reg[DV_N][i]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            o_valid_reg <= dv_valid_reg[DV_N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_u_reg    <= u_next;
            o_side_reg <= dv_side_reg[DV_N];
        end
    end

    assign out_valid = o_valid_reg;
    assign out_u     = o_u_reg;
    assign out_side  = o_side_reg;

endmodule

// ===== hw/rtl/lookat_view_matrix_core.sv =====
// Look-at view matrix: top level with stream ports and the axis pipeline.
//
// One request on the slave stream carries eye, target and up vectors in signed
// Q16.16. One result request on the master stream carries the right, up and back
// rows in Q2.30 and the three saturated Q16.16 translations.
// Throughput: one request per cycle; a new request enters every cycle that the
// pipeline advances.
// Two normalizer pipelines of 69 stages each (32 square-root stages plus 31
// restoring-divide stages per normalizer) and 11 stages of subtract, cross
// product, round and dot-product logic lie between acceptance and the result
// on the master side.
// The whole pipeline advances together; when the receiver holds tready low
// with a result waiting, every stage holds and s_axis_tready drops, so nothing
// is lost or repeated. An empty output register never blocks the pipeline.
// Reset clears all valid bits; the payload registers are not reset. There is
// no configuration and no state shared between requests.
module lookat_view_matrix_core
    import lvm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, upvec_x, upvec_y, upvec_z
    input  logic [287:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // right_x, right_y, right_z, upaxis_x, upaxis_y, upaxis_z,
    // back_x, back_y, back_z, shift_0, shift_1, shift_2
    output logic [383:0] m_axis_tdata
);

    typedef struct packed {
        logic [2:0][31:0] eye;
        logic [2:0][31:0] upm;
        logic [2:0]       upneg;
        logic [5:0]       uplen;
    } n1_side_t;

    typedef struct packed {
        logic [2:0][31:0] eye;
        logic [2:0][31:0] back;
    } n2_side_t;

    // Round a Q4.60 difference to Q2.30, halves away from zero, saturate
    function automatic logic [31:0] round_sat(input logic signed [63:0] t);
        logic [63:0] mag;
        logic [63:0] m;
        mag = t[63] ? (~t + 1'b1) : t;
        m   = (mag + 64'(1 << (ROT_FRAC_BITS - 1))) >> ROT_FRAC_BITS;
        if (t[63])
        begin
            round_sat = (m > 64'h8000_0000) ? 32'h8000_0000 : -m[31:0];
        end
        else
        begin
            round_sat = (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
        end
    endfunction

    // Minus the dot product rounded half up to the position format, saturated
    function automatic logic [31:0] trans(input logic signed [65:0] p);
        logic signed [65:0] r;
        logic signed [65:0] h;
        r = p + 66'sd536870912;
        h = r >>> ROT_FRAC_BITS;
        h = -h;
        if (h > 66'sd2147483647)
        begin
            trans = 32'h7FFF_FFFF;
        end
        else if (h < -66'sd2147483648)
        begin
            trans = 32'h8000_0000;
        end
        else
        begin
            trans = h[31:0];
        end
    endfunction

    logic en;

    // Advance the whole pipeline while the output slot is free or being taken
    logic out_valid_reg;
    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    // Stage I0: capture the request
    logic             i0_valid_reg;
    logic [2:0][31:0] i0_eye_reg;
    logic [2:0][31:0] i0_tgt_reg;
    logic [2:0][31:0] i0_up_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i0_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            i0_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                i0_eye_reg[i] <= s_axis_tdata[32*i +: 32];
                i0_tgt_reg[i] <= s_axis_tdata[96 + 32*i +: 32];
                i0_up_reg[i]  <= s_axis_tdata[192 + 32*i +: 32];
            end
        end
    end

    // Stage I1: view direction and up magnitudes with their bit length
    logic [2:0][32:0] i1_d_next;
    logic [2:0][31:0] i1_upm_next;
    logic [31:0]      i1_upor;
    logic [6:0]       i1_uplen_full;
    logic             i1_valid_reg;
    logic [2:0][32:0] i1_d_reg;
    n1_side_t         i1_side_reg;

    always_comb
    begin
        i1_upor = '0;
        for (int i = 0; i < 3; i++)
        begin
            i1_d_next[i]   = {i0_eye_reg[i][31], i0_eye_reg[i]}
                             - {i0_tgt_reg[i][31], i0_tgt_reg[i]};
            i1_upm_next[i] = i0_up_reg[i][31] ? (~i0_up_reg[i] + 1'b1) : i0_up_reg[i];
            i1_upor        = i1_upor | i1_upm_next[i];
        end
        i1_uplen_full = bit_len64(64'(i1_upor));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            i1_valid_reg <= i0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i1_d_reg          <= i1_d_next;
            i1_side_reg.eye   <= i0_eye_reg;
            i1_side_reg.upm   <= i1_upm_next;
            for (int i = 0; i < 3; i++)
            begin
                i1_side_reg.upneg[i] <= i0_up_reg[i][31];
            end
            i1_side_reg.uplen <= i1_uplen_full[5:0];
        end
    end

    // Normalize eye minus target into the back axis
    logic             n1_valid;
    logic [2:0][31:0] n1_back;
    n1_side_t         n1_side;

    lvm_norm #(
        .IN_W   (33),
        .SIDE_W ($bits(n1_side_t))
    ) u_norm_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (i1_valid_reg),
        .in_c      (i1_d_reg),
        .in_side   (i1_side_reg),
        .out_valid (n1_valid),
        .out_u     (n1_back),
        .out_side  (n1_side)
    );

    // Stage X1: block-scale the up vector
    logic [2:0][30:0] x1_ups_next;
    logic [61:0]      x1_sh;
    logic             x1_valid_reg;
    logic [2:0][30:0] x1_ups_reg;
    logic [2:0][31:0] x1_back_reg;
    logic [2:0][31:0] x1_eye_reg;

    always_comb
    begin
        x1_sh = '0;
        for (int i = 0; i < 3; i++)
        begin
            x1_sh          = {n1_side.upm[i], 30'b0} >> n1_side.uplen;
            x1_ups_next[i] = n1_side.upneg[i] ? -{1'b0, x1_sh[29:0]} : {1'b0, x1_sh[29:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            x1_valid_reg <= n1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_ups_reg  <= x1_ups_next;
            x1_back_reg <= n1_back;
            x1_eye_reg  <= n1_side.eye;
        end
    end

    // Stage X2: cross product terms of up and back
    logic             x2_valid_reg;
    logic [5:0][62:0] x2_p_reg;
    logic [2:0][31:0] x2_back_reg;
    logic [2:0][31:0] x2_eye_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            x2_valid_reg <= x1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x2_p_reg[0] <= 63'($signed(x1_ups_reg[1]) * $signed(x1_back_reg[2]));
            x2_p_reg[1] <= 63'($signed(x1_ups_reg[2]) * $signed(x1_back_reg[1]));
            x2_p_reg[2] <= 63'($signed(x1_ups_reg[2]) * $signed(x1_back_reg[0]));
            x2_p_reg[3] <= 63'($signed(x1_ups_reg[0]) * $signed(x1_back_reg[2]));
            x2_p_reg[4] <= 63'($signed(x1_ups_reg[0]) * $signed(x1_back_reg[1]));
            x2_p_reg[5] <= 63'($signed(x1_ups_reg[1]) * $signed(x1_back_reg[0]));
            x2_back_reg <= x1_back_reg;
            x2_eye_reg  <= x1_eye_reg;
        end
    end

    // Stage X3: cross product differences
    logic             x3_valid_reg;
    logic [2:0][62:0] x3_cr_reg;
    n2_side_t         x3_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            x3_valid_reg <= x2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                x3_cr_reg[i] <= x2_p_reg[2*i] - x2_p_reg[2*i+1];
            end
            x3_side_reg.eye  <= x2_eye_reg;
            x3_side_reg.back <= x2_back_reg;
        end
    end

    // Normalize the cross product into the right axis
    logic             n2_valid;
    logic [2:0][31:0] n2_right;
    n2_side_t         n2_side;

    lvm_norm #(
        .IN_W   (63),
        .SIDE_W ($bits(n2_side_t))
    ) u_norm_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (x3_valid_reg),
        .in_c      (x3_cr_reg),
        .in_side   (x3_side_reg),
        .out_valid (n2_valid),
        .out_u     (n2_right),
        .out_side  (n2_side)
    );

    // Stage U1: true-up terms and dot-product terms for right and back
    logic             u1_valid_reg;
    logic [5:0][63:0] u1_tp_reg;
    logic [2:0][63:0] u1_rp_reg;
    logic [2:0][63:0] u1_bp_reg;
    logic [2:0][31:0] u1_right_reg;
    logic [2:0][31:0] u1_back_reg;
    logic [2:0][31:0] u1_eye_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            u1_valid_reg <= n2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                u1_tp_reg[2*i]   <= $signed(n2_side.back[(i+1)%3]) * $signed(n2_right[(i+2)%3]);
                u1_tp_reg[2*i+1] <= $signed(n2_side.back[(i+2)%3]) * $signed(n2_right[(i+1)%3]);
                u1_rp_reg[i]     <= $signed(n2_right[i]) * $signed(n2_side.eye[i]);
                u1_bp_reg[i]     <= $signed(n2_side.back[i]) * $signed(n2_side.eye[i]);
            end
            u1_right_reg <= n2_right;
            u1_back_reg  <= n2_side.back;
            u1_eye_reg   <= n2_side.eye;
        end
    end

    // Stage U2: true-up differences and dot sums
    logic             u2_valid_reg;
    logic [2:0][63:0] u2_t_reg;
    logic [65:0]      u2_rsum_reg;
    logic [65:0]      u2_bsum_reg;
    logic [2:0][31:0] u2_right_reg;
    logic [2:0][31:0] u2_back_reg;
    logic [2:0][31:0] u2_eye_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            u2_valid_reg <= u1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                u2_t_reg[i] <= u1_tp_reg[2*i] - u1_tp_reg[2*i+1];
            end
            u2_rsum_reg  <= 66'($signed(u1_rp_reg[0])) + 66'($signed(u1_rp_reg[1]))
                            + 66'($signed(u1_rp_reg[2]));
            u2_bsum_reg  <= 66'($signed(u1_bp_reg[0])) + 66'($signed(u1_bp_reg[1]))
                            + 66'($signed(u1_bp_reg[2]));
            u2_right_reg <= u1_right_reg;
            u2_back_reg  <= u1_back_reg;
            u2_eye_reg   <= u1_eye_reg;
        end
    end

    // Stage U3: round the true-up axis, finish right and back translations
    logic             u3_valid_reg;
    logic [2:0][31:0] u3_upax_reg;
    logic [31:0]      u3_rtr_reg;
    logic [31:0]      u3_btr_reg;
    logic [2:0][31:0] u3_right_reg;
    logic [2:0][31:0] u3_back_reg;
    logic [2:0][31:0] u3_eye_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            u3_valid_reg <= u2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                u3_upax_reg[i] <= round_sat($signed(u2_t_reg[i]));
            end
            u3_rtr_reg   <= trans($signed(u2_rsum_reg));
            u3_btr_reg   <= trans($signed(u2_bsum_reg));
            u3_right_reg <= u2_right_reg;
            u3_back_reg  <= u2_back_reg;
            u3_eye_reg   <= u2_eye_reg;
        end
    end

    // Stage U4: dot-product terms for the true-up axis
    logic             u4_valid_reg;
    logic [2:0][63:0] u4_up_reg;
    logic [2:0][31:0] u4_upax_reg;
    logic [31:0]      u4_rtr_reg;
    logic [31:0]      u4_btr_reg;
    logic [2:0][31:0] u4_right_reg;
    logic [2:0][31:0] u4_back_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            u4_valid_reg <= u3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                u4_up_reg[i] <= $signed(u3_upax_reg[i]) * $signed(u3_eye_reg[i]);
            end
            u4_upax_reg  <= u3_upax_reg;
            u4_rtr_reg   <= u3_rtr_reg;
            u4_btr_reg   <= u3_btr_reg;
            u4_right_reg <= u3_right_reg;
            u4_back_reg  <= u3_back_reg;
        end
    end

    // Stage U5: true-up dot sum
    logic             u5_valid_reg;
    logic [65:0]      u5_usum_reg;
    logic [2:0][31:0] u5_upax_reg;
    logic [31:0]      u5_rtr_reg;
    logic [31:0]      u5_btr_reg;
    logic [2:0][31:0] u5_right_reg;
    logic [2:0][31:0] u5_back_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            u5_valid_reg <= u4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u5_usum_reg  <= 66'($signed(u4_up_reg[0])) + 66'($signed(u4_up_reg[1]))
                            + 66'($signed(u4_up_reg[2]));
            u5_upax_reg  <= u4_upax_reg;
            u5_rtr_reg   <= u4_rtr_reg;
            u5_btr_reg   <= u4_btr_reg;
            u5_right_reg <= u4_right_reg;
            u5_back_reg  <= u4_back_reg;
        end
    end

    // Output register: last translation and the packed result request
    logic [2:0][31:0] out_right_reg;
    logic [2:0][31:0] out_upax_reg;
    logic [2:0][31:0] out_back_reg;
    logic [2:0][31:0] out_shift_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= u5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_right_reg    <= u5_right_reg;
            out_upax_reg     <= u5_upax_reg;
            out_back_reg     <= u5_back_reg;
            out_shift_reg[0] <= u5_rtr_reg;
            out_shift_reg[1] <= trans($signed(u5_usum_reg));
            out_shift_reg[2] <= u5_btr_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_shift_reg, out_back_reg, out_upax_reg, out_right_reg};

    // The back x and right z components of the normalized rows never exceed unit length
    a_back_unit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ($signed(out_back_reg[0]) <= $signed(ONE_Q30))
                       && ($signed(out_back_reg[0]) >= -$signed(ONE_Q30)))
        else $error("back axis exceeds unit length");

    a_right_unit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ($signed(out_right_reg[2]) <= $signed(ONE_Q30))
                       && ($signed(out_right_reg[2]) >= -$signed(ONE_Q30)))
        else $error("right axis exceeds unit length");

    // A zero right row gives a zero true-up row
    a_zero_right: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_right_reg == '0) |-> (out_upax_reg == '0))
        else $error("true up axis nonzero with zero right axis");

    // A zero back row gives a zero back translation
    a_zero_back: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_back_reg == '0) |-> (out_shift_reg[2] == '0))
        else $error("back translation nonzero with zero back axis");

endmodule
